FILE: src/dwrp_pkg.sv
// ----------------------------------------------------------------------------
// dwrp_pkg
// Shared types and constants for the dirty word run packer.
// ----------------------------------------------------------------------------
package dwrp_pkg;

  localparam int unsigned MAX_RUN_BYTES = 250;
  localparam int unsigned MAX_GAP_BYTES = 8;
  localparam int unsigned CAP_RESERVE   = 12;
  localparam int unsigned HEADER_BYTES  = 5;
  localparam int unsigned ID_BYTES      = 4;
  // unchanged words that can be pending when a changed word arrives
  localparam int unsigned HOLD_DEPTH    = (MAX_GAP_BYTES + 1) / 2 - 1;
  localparam int unsigned DATA_SLOTS    = HOLD_DEPTH + 1;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_SEND   = 2'd2;

  localparam logic CFG_CAPACITY  = 1'b0;
  localparam logic CFG_MEMORY_ID = 1'b1;

  localparam logic [12:0] CAPACITY_RESET = 13'd1024;
  localparam logic [31:0] MEMORY_ID_RESET = 32'd0;

  typedef struct packed {
    logic [15:0] word_value;
    logic [31:0] byte_addr;
    logic        is_changed;
    logic        region_end;
  } item_t;

  typedef struct packed {
    logic [1:0]  rec_kind;
    logic [15:0] data_word;
    logic [31:0] run_addr;
    logic [7:0]  run_bytes;
    logic [12:0] msg_bytes;
    logic [31:0] msg_memory_id;
    logic        truncated;
    logic        last;
  } result_t;

  // all records caused by one item, in emit order: data, header, send
  typedef struct packed {
    logic [2:0]                   data_n;
    logic [DATA_SLOTS-1:0][15:0]  words;
    logic                         hdr_vld;
    logic [31:0]                  hdr_addr;
    logic [7:0]                   hdr_bytes;
    logic                         snd_vld;
    logic [12:0]                  snd_bytes;
    logic [31:0]                  snd_id;
    logic                         snd_trunc;
  } batch_t;

endpackage

FILE: src/dwrp_step.sv
// ----------------------------------------------------------------------------
// dwrp_step
// Run/message state and the single-pass update for one registered item.
// ----------------------------------------------------------------------------
module dwrp_step import dwrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  item_t       item,
  input  logic [12:0] capacity,
  input  logic [31:0] memory_id,
  output batch_t      batch,
  output logic        batch_vld
);

  logic        run_open;
  logic [31:0] run_start_addr;
  logic [7:0]  run_len_bytes;
  logic [3:0]  gap_bytes;
  logic [1:0]  held_count;
  logic [15:0] held_words [HOLD_DEPTH];
  logic [12:0] fill_bytes;
  logic        region_stopped;

  logic [12:0] limit;
  logic        open1;
  logic [31:0] start1;
  logic [7:0]  len1;
  logic [3:0]  gap1;
  logic [2:0]  cnt1;
  logic [12:0] fill1;
  logic        hold_we;
  logic        close_cond;
  logic        hdr;
  logic [12:0] fill_after;
  logic        trunc;
  logic        flush;
  logic        snd;
  logic [2:0]  data_n;

  always_comb begin
    limit = (capacity > 13'(CAP_RESERVE)) ? capacity - 13'(CAP_RESERVE) : '0;
    open1   = run_open;
    start1  = run_start_addr;
    len1    = run_len_bytes;
    gap1    = gap_bytes;
    cnt1    = {1'b0, held_count};
    fill1   = fill_bytes;
    hold_we = 1'b0;
    if (run_open) begin
      len1  = run_len_bytes + 8'd2;
      fill1 = fill_bytes + 13'd2;
      if (item.is_changed) begin
        cnt1 = 3'd0;
        gap1 = 4'd0;
      end else begin
        hold_we = (held_count < 2'(HOLD_DEPTH));
        cnt1    = {1'b0, held_count} + 3'd1;
        gap1    = gap_bytes + 4'd2;
      end
    end else if (item.is_changed) begin
      open1  = 1'b1;
      start1 = item.byte_addr;
      len1   = 8'd2;
      gap1   = 4'd0;
      cnt1   = 3'd0;
      fill1  = fill_bytes + 13'(HEADER_BYTES + 2);
    end

    close_cond = (fill1 >= limit) || (gap1 >= 4'(MAX_GAP_BYTES))
              || (len1 >= 8'(MAX_RUN_BYTES));
    hdr        = open1 && (close_cond || item.region_end);
    fill_after = hdr ? fill1 - {9'b0, gap1} : fill1;
    trunc      = close_cond && (fill_after >= limit);
    flush      = trunc || item.region_end;
    snd        = flush && (fill_after > 13'(ID_BYTES));
    data_n     = item.is_changed ? {1'b0, held_count} + 3'd1 : 3'd0;

    batch.data_n = data_n;
    for (int i = 0; i < int'(DATA_SLOTS); i++) begin
      if (i < int'(HOLD_DEPTH) && held_count != 2'(i)) begin
        batch.words[i] = held_words[i];
      end else begin
        batch.words[i] = item.word_value;
      end
    end
    batch.hdr_vld   = hdr;
    batch.hdr_addr  = start1;
    batch.hdr_bytes = len1 - {4'b0, gap1};
    batch.snd_vld   = snd;
    batch.snd_bytes = fill_after;
    batch.snd_id    = memory_id;
    batch.snd_trunc = trunc;

    batch_vld = !region_stopped && ((data_n != 3'd0) || hdr || snd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open       <= 1'b0;
      run_start_addr <= '0;
      run_len_bytes  <= '0;
      gap_bytes      <= '0;
      held_count     <= '0;
      fill_bytes     <= 13'(ID_BYTES);
      region_stopped <= 1'b0;
    end else if (adv) begin
      if (region_stopped) begin
        if (item.region_end) begin
          region_stopped <= 1'b0;
        end
      end else begin
        if (hdr) begin
          run_open       <= 1'b0;
          run_start_addr <= '0;
          run_len_bytes  <= '0;
          gap_bytes      <= '0;
          held_count     <= '0;
        end else begin
          run_open       <= open1;
          run_start_addr <= start1;
          run_len_bytes  <= len1;
          gap_bytes      <= gap1;
          held_count     <= cnt1[1:0];
        end
        fill_bytes     <= flush ? 13'(ID_BYTES) : fill_after;
        region_stopped <= trunc && !item.region_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && !region_stopped && hold_we) begin
      held_words[held_count] <= item.word_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_stop_closed: assert property (@(posedge clk) disable iff (rst)
    region_stopped |-> !run_open)
    else $error("region stopped with a run still open");
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    !run_open |-> (held_count == 2'd0) && (gap_bytes == 4'd0))
    else $error("gap state left over with no run open");
`endif

endmodule

FILE: src/dwrp_outq.sv
// ----------------------------------------------------------------------------
// dwrp_outq
// Two-entry batch queue with a serializer, one result per transaction.
// ----------------------------------------------------------------------------
module dwrp_outq import dwrp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  batch_t  batch,
  output logic    space,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  batch_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [2:0] pos;

  batch_t     head;
  logic [2:0] total;
  logic       pop;

  always_comb begin
    head  = entries[rd_ptr];
    total = head.data_n + {2'b0, head.hdr_vld} + {2'b0, head.snd_vld};
    space = (count != 2'd2);
    result_valid = (count != 2'd0);

    result = '0;
    priority if (pos < head.data_n) begin
      result.rec_kind  = KIND_DATA;
      result.data_word = head.words[pos[1:0]];
    end else if (pos == head.data_n && head.hdr_vld) begin
      result.rec_kind  = KIND_HEADER;
      result.run_addr  = head.hdr_addr;
      result.run_bytes = head.hdr_bytes;
    end else begin
      result.rec_kind      = KIND_SEND;
      result.msg_bytes     = head.snd_bytes;
      result.msg_memory_id = head.snd_id;
      result.truncated     = head.snd_trunc;
    end
    result.last = (pos == total - 3'd1);
    pop = result_valid && !result_stall && result.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
      pos    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
        pos    <= '0;
      end else if (result_valid && !result_stall) begin
        pos <= pos + 3'd1;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= batch;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("batch queue overflow");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pos < total))
    else $error("serializer position past end of batch");
`endif

endmodule

FILE: src/dirty_word_run_packer_unit.sv
// ----------------------------------------------------------------------------
// dirty_word_run_packer_unit
// Groups changed memory words into runs and packs them into messages.
// ----------------------------------------------------------------------------
// Path: each item is registered in the input stage, then its batch in the batch queue.
// Throughput: 1 item per cycle while each item causes at most one result and the
//   output is not stalled; one record leaves per unstalled cycle, so an item's
//   records hold the output until taken (the two-entry batch queue absorbs bursts).
// Reset: synchronous; run state cleared, message fill back to the 4-byte id,
//   message_capacity 1024, memory_id 0. Held words need no clearing.
module dirty_word_run_packer_unit import dwrp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers
  logic [12:0] capacity;
  logic [31:0] memory_id;

  // input register stage
  logic   s1_vld;
  item_t  s1_item;

  logic   adv;
  logic   space;
  logic   batch_vld;
  batch_t batch;
  logic   accept;

  // Writes are always taken; the user must send them only while idle; no block check.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RESET;
      memory_id <= MEMORY_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAPACITY:  capacity  <= cfg_data[12:0];
        CFG_MEMORY_ID: memory_id <= cfg_data;
      endcase
    end
  end

  // The registered item is processed once the queue can take its batch;
  // items producing no record never wait.
  assign adv        = s1_vld && (space || !batch_vld);
  assign item_stall = s1_vld && !adv;
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (accept) begin
      s1_vld <= 1'b1;
    end else if (adv) begin
      s1_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
    end
  end

  // run tracking and record generation
  dwrp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .item      (s1_item),
    .capacity  (capacity),
    .memory_id (memory_id),
    .batch     (batch),
    .batch_vld (batch_vld)
  );

  // batch queue and one-record-per-transaction output
  dwrp_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (adv && batch_vld),
    .batch        (batch),
    .space        (space),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
